// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque package
// Request and status codes, field widths and the controller command word.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Controller to datapath command word.
  typedef struct packed {
    logic load;  // capture the request word
    logic exec;  // run the ring access
  } deq_cmd_t;

endpackage

// ===== rtl/deq_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface deq_req_if;
  import deq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic signed [VALUE_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

// ===== rtl/deq_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface deq_rsp_if;
  import deq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] pop_value;
  logic [1:0]                status;
  logic [COUNT_W-1:0]        item_count;

  modport source (output valid, output pop_value, output status, output item_count,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input item_count,
                  output ready);
endinterface

// ===== rtl/deq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque controller
// Sequences accept, ring access and result handoff for one word at a time.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output deq_pkg::deq_cmd_t cmd_o
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            state_q    <= S_EXEC;
            in_ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          state_q     <= S_RESP;
          out_valid_q <= 1'b1;
        end
        S_RESP: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = in_valid_i && in_ready_q;
  assign cmd_o.exec  = (state_q == S_EXEC);

endmodule

// ===== rtl/deq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque datapath
// Ring storage, front pointer, fill count and result registers.
// ----------------------------------------------------------------------------
module deq_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  deq_pkg::deq_cmd_t                  cmd_i,
  input  logic [1:0]                         req_type_i,
  input  logic signed [deq_pkg::VALUE_W-1:0] push_value_i,
  output logic signed [deq_pkg::VALUE_W-1:0] pop_value_o,
  output logic [1:0]                         status_o,
  output logic [deq_pkg::COUNT_W-1:0]        item_count_o
);
  import deq_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [VALUE_W-1:0] mem [DEPTH];

  req_e               req_q;
  logic [VALUE_W-1:0] val_q;
  logic [IW-1:0]      front_q, front_d;
  logic [CW-1:0]      count_q, count_d;
  logic [VALUE_W-1:0] rd_q;
  status_e            status_q, status_d;
  logic               popok_q;

  logic          is_push, full, empty, ok;
  logic [IW-1:0] front_dec, front_inc, rear_slot, slot;
  logic [CW-1:0] offset;
  logic [SW-1:0] sum;

  // Capture the request word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_e'(req_type_i);
      val_q <= push_value_i;
    end
  end

  assign is_push = (req_q == REQ_PUSH_FRONT) || (req_q == REQ_PUSH_REAR);
  assign full    = (count_q == CW'(DEPTH));
  assign empty   = (count_q == '0);
  assign ok      = is_push ? !full : !empty;

  assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
  assign front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + IW'(1);

  // Rear slot: one past the rear value for a push, the rear value for a pop.
  assign offset    = (req_q == REQ_POP_REAR) ? count_q - CW'(1) : count_q;
  assign sum       = SW'(front_q) + SW'(offset);
  assign rear_slot = (sum >= SW'(DEPTH)) ? IW'(sum - SW'(DEPTH)) : IW'(sum);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    slot     = rear_slot;
    status_d = STAT_DONE;
    case (req_q)
      REQ_PUSH_FRONT: begin
        slot = front_dec;
        if (full) status_d = STAT_FULL;
        else begin
          front_d = front_dec;
          count_d = count_q + CW'(1);
        end
      end
      REQ_PUSH_REAR: begin
        if (full) status_d = STAT_FULL;
        else count_d = count_q + CW'(1);
      end
      REQ_POP_FRONT: begin
        slot = front_q;
        if (empty) status_d = STAT_EMPTY;
        else begin
          front_d = front_inc;
          count_d = count_q - CW'(1);
        end
      end
      REQ_POP_REAR: begin
        if (empty) status_d = STAT_EMPTY;
        else count_d = count_q - CW'(1);
      end
      default: begin
        status_d = STAT_DONE;
      end
    endcase
  end

  // Ring storage: one write on a successful push and one registered read per access.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && is_push && ok) begin
      mem[slot] <= val_q;
    end
    if (cmd_i.exec) begin
      rd_q <= mem[slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      status_q <= STAT_DONE;
      popok_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      front_q  <= front_d;
      count_q  <= count_d;
      status_q <= status_d;
      popok_q  <= ok && !is_push;
    end
  end

  assign pop_value_o  = popok_q ? rd_q : '0;
  assign status_o     = status_q;
  assign item_count_o = COUNT_W'(count_q);

endmodule

// ===== rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue
// Ring buffer of DEPTH signed 32-bit words with push and pop at both ends.
// ----------------------------------------------------------------------------
// Timing: an accepted request passes through the ring access state, and the
//   result word is registered and held until it is taken.
// Flow: a new request is taken only after the result is handed off;
//   the controller steps accept, ring access and result handoff one at a time.
// Reset: front pointer and fill count clear to zero and the block is ready at
//   once; ring contents stay undefined until written, with no clearing pass.
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);
  import deq_pkg::*;

  deq_cmd_t cmd;

  // Controller: take one request word, run the ring access, hand off the result.
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // Datapath: ring storage, pointers and the held result word.
  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_type_i   (req_i.req_type),
    .push_value_i (req_i.push_value),
    .pop_value_o  (rsp_o.pop_value),
    .status_o     (rsp_o.status),
    .item_count_o (rsp_o.item_count)
  );

endmodule

// ===== rtl/deq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque port checker
// Watches the request and response channels of the deque over time.
// ----------------------------------------------------------------------------
module deq_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               req_valid_i,
  input logic                               req_ready_i,
  input logic                               rsp_valid_i,
  input logic                               rsp_ready_i,
  input logic signed [deq_pkg::VALUE_W-1:0] pop_value_i,
  input logic [1:0]                         status_i,
  input logic [deq_pkg::COUNT_W-1:0]        item_count_i
);
  import deq_pkg::*;

  // Every accepted word yields a result once the ring access state has passed.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |-> ##2 rsp_valid_i)
    else $error("result word missing two cycles after accept");

  // No new word is taken while a result is held.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i)
    else $error("request accepted while a result is pending");

  // A failed request returns no value.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != STAT_DONE) |-> pop_value_i == '0)
    else $error("nonzero value on a failed request");

  // An empty report means the deque holds nothing.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STAT_EMPTY) |-> item_count_i == '0)
    else $error("empty status with nonzero count");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(pop_value_i))
    else $error("stalled result word changed");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .pop_value_i  (rsp_o.pop_value),
  .status_i     (rsp_o.status),
  .item_count_i (rsp_o.item_count)
);
